// ----- src/png_unf_pkg.sv -----
package png_unf_pkg;

  localparam int MAX_ROW_BYTES   = 8192;
  localparam int MAX_PIXEL_BYTES = 8;

  localparam int BYTE_W      = 8;
  localparam int COL_W       = $clog2(MAX_ROW_BYTES);
  localparam int LEN_W       = COL_W + 1;
  localparam int SLOT_W      = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int ROW_BYTES_W = 14;
  localparam int BPP_W       = 4;
  localparam int FILTER_W    = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 14;

  localparam logic [FILTER_W-1:0] FILT_NONE  = 3'd0;
  localparam logic [FILTER_W-1:0] FILT_SUB   = 3'd1;
  localparam logic [FILTER_W-1:0] FILT_UP    = 3'd2;
  localparam logic [FILTER_W-1:0] FILT_AVG   = 3'd3;
  localparam logic [FILTER_W-1:0] FILT_PAETH = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BPP       = 2'd1;

  typedef struct packed {
    logic [BYTE_W-1:0]   data;
    logic [FILTER_W-1:0] filter;
    logic                first_row;
    logic                has_left;
    logic                last;
    logic                bad;
    logic [SLOT_W-1:0]   slot;
    logic [COL_W-1:0]    col;
  } recon_op_t;

endpackage

// ----- src/png_unf_if.sv -----
interface png_unf_in_if import png_unf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              first_of_image;

  modport source (output valid, data_byte, first_of_image, input ready);
  modport sink   (input valid, data_byte, first_of_image, output ready);
endinterface

interface png_unf_out_if import png_unf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] pixel_byte;
  logic              last_of_row;
  logic              bad_filter;

  modport source (output valid, pixel_byte, last_of_row, bad_filter, input ready);
  modport sink   (input valid, pixel_byte, last_of_row, bad_filter, output ready);
endinterface

interface png_unf_cfg_if import png_unf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/png_unf_line_ram.sv -----
module png_unf_line_ram import png_unf_pkg::*; (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [COL_W-1:0]  rd_addr,
  output logic [BYTE_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [COL_W-1:0]  wr_addr,
  input  logic [BYTE_W-1:0] wr_data
);

  logic [BYTE_W-1:0] mem [MAX_ROW_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/png_unf_ctrl.sv -----
module png_unf_ctrl import png_unf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  png_unf_in_if.sink        pix_in,
  png_unf_cfg_if.sink       cfg,
  input  logic              op_ready,
  output logic              op_push,
  output recon_op_t         op,
  output logic              rd_en,
  output logic [COL_W-1:0]  rd_addr
);

  logic [ROW_BYTES_W-1:0] row_bytes;
  logic [BPP_W-1:0]       bytes_per_pixel;
  logic [COL_W-1:0]       column;
  logic [FILTER_W-1:0]    row_filter;
  logic                   awaiting_type;
  logic                   on_first_row;
  logic                   halted;
  logic [SLOT_W-1:0]      mod_cnt [MAX_PIXEL_BYTES];

  logic              accept;
  logic              first;
  logic              halted_eff;
  logic              await_eff;
  logic              first_row_eff;
  logic              is_type;
  logic              is_bad;
  logic              is_data;
  logic              last;
  logic              has_left;
  logic [LEN_W-1:0]  eff_len;
  logic [BPP_W-1:0]  eff_bpp;
  logic [SLOT_W-1:0] slot;

  assign cfg.ready    = 1'b1;
  assign pix_in.ready = op_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes       <= ROW_BYTES_W'(1);
      bytes_per_pixel <= BPP_W'(1);
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_ROW_BYTES: row_bytes       <= cfg.data[ROW_BYTES_W-1:0];
        CFG_BPP:       bytes_per_pixel <= cfg.data[BPP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (row_bytes == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(row_bytes) > MAX_ROW_BYTES) begin
      eff_len = LEN_W'(MAX_ROW_BYTES);
    end else begin
      eff_len = LEN_W'(row_bytes);
    end
    if (bytes_per_pixel == '0) begin
      eff_bpp = BPP_W'(1);
    end else if (32'(bytes_per_pixel) > MAX_PIXEL_BYTES) begin
      eff_bpp = BPP_W'(MAX_PIXEL_BYTES);
    end else begin
      eff_bpp = bytes_per_pixel;
    end
  end

  assign accept        = pix_in.valid && op_ready;
  assign first         = pix_in.first_of_image;
  assign halted_eff    = halted && !first;
  assign await_eff     = awaiting_type || first;
  assign first_row_eff = on_first_row || first;
  assign is_type       = !halted_eff && await_eff;
  assign is_bad        = is_type && (pix_in.data_byte > BYTE_W'(FILT_PAETH));
  assign is_data       = !halted_eff && !await_eff;
  assign slot          = mod_cnt[SLOT_W'(eff_bpp - BPP_W'(1))];
  assign has_left      = column >= COL_W'(eff_bpp);
  assign last          = (LEN_W'(column) + LEN_W'(1)) >= eff_len;

  assign op_push = accept && (is_data || is_bad);
  assign rd_en   = accept && is_data;
  assign rd_addr = column;

  always_comb begin
    op.data      = pix_in.data_byte;
    op.filter    = row_filter;
    op.first_row = first_row_eff;
    op.has_left  = has_left;
    op.last      = last;
    op.bad       = is_bad;
    op.slot      = slot;
    op.col       = column;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column        <= '0;
      row_filter    <= FILT_NONE;
      awaiting_type <= 1'b1;
      on_first_row  <= 1'b1;
      halted        <= 1'b0;
      for (int d = 0; d < MAX_PIXEL_BYTES; d++) begin
        mod_cnt[d] <= '0;
      end
    end else if (accept) begin
      halted        <= halted_eff || is_bad;
      awaiting_type <= is_type ? is_bad : (is_data ? last : await_eff);
      on_first_row  <= (is_data && last) ? 1'b0 : first_row_eff;
      if (is_type) begin
        column <= '0;
        for (int d = 0; d < MAX_PIXEL_BYTES; d++) begin
          mod_cnt[d] <= '0;
        end
        if (!is_bad) begin
          row_filter <= pix_in.data_byte[FILTER_W-1:0];
        end
      end else if (is_data) begin
        if (last) begin
          column <= '0;
          for (int d = 0; d < MAX_PIXEL_BYTES; d++) begin
            mod_cnt[d] <= '0;
          end
        end else begin
          column <= column + COL_W'(1);
          for (int d = 0; d < MAX_PIXEL_BYTES; d++) begin
            mod_cnt[d] <= (mod_cnt[d] == SLOT_W'(d)) ? '0 : mod_cnt[d] + SLOT_W'(1);
          end
        end
      end
    end
  end

endmodule

// ----- src/png_unf_recon.sv -----
module png_unf_recon import png_unf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              op_push,
  input  recon_op_t         op,
  output logic              op_ready,
  input  logic [BYTE_W-1:0] rd_data,
  output logic              wr_en,
  output logic [COL_W-1:0]  wr_addr,
  output logic [BYTE_W-1:0] wr_data,
  png_unf_out_if.source     pix_out
);

  logic              s2_valid;
  recon_op_t         s2_op;
  logic              s2_adv;
  logic [BYTE_W-1:0] left_bytes   [MAX_PIXEL_BYTES];
  logic [BYTE_W-1:0] upleft_bytes [MAX_PIXEL_BYTES];

  logic [BYTE_W-1:0]   a;
  logic [BYTE_W-1:0]   b;
  logic [BYTE_W-1:0]   c;
  logic [BYTE_W:0]     avg_sum;
  logic signed [9:0]   d_bc;
  logic signed [9:0]   d_ac;
  logic signed [9:0]   d_abc;
  logic [9:0]          pa;
  logic [9:0]          pb;
  logic [9:0]          pc;
  logic [BYTE_W-1:0]   paeth;
  logic [BYTE_W-1:0]   pred;
  logic [BYTE_W-1:0]   res;

  assign s2_adv   = s2_valid && (!pix_out.valid || pix_out.ready);
  assign op_ready = !s2_valid || s2_adv;

  always_comb begin
    a = s2_op.has_left ? left_bytes[s2_op.slot] : '0;
    b = s2_op.first_row ? '0 : rd_data;
    c = (s2_op.first_row || !s2_op.has_left) ? '0 : upleft_bytes[s2_op.slot];

    avg_sum = {1'b0, a} + {1'b0, b};

    d_bc  = $signed({2'b00, b}) - $signed({2'b00, c});
    d_ac  = $signed({2'b00, a}) - $signed({2'b00, c});
    d_abc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
    pa    = (d_bc  < 0) ? 10'(-d_bc)  : 10'(d_bc);
    pb    = (d_ac  < 0) ? 10'(-d_ac)  : 10'(d_ac);
    pc    = (d_abc < 0) ? 10'(-d_abc) : 10'(d_abc);

    if (pa <= pb && pa <= pc) begin
      paeth = a;
    end else if (pb <= pc) begin
      paeth = b;
    end else begin
      paeth = c;
    end

    case (s2_op.filter)
      FILT_NONE:  pred = '0;
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = avg_sum[BYTE_W:1];
      FILT_PAETH: pred = paeth;
      default:    pred = '0;
    endcase

    res = s2_op.data + pred;
  end

  assign wr_en   = s2_adv && !s2_op.bad;
  assign wr_addr = s2_op.col;
  assign wr_data = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (op_push) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op_push) begin
      s2_op <= op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_bytes[i]   <= '0;
        upleft_bytes[i] <= '0;
      end
    end else if (wr_en) begin
      left_bytes[s2_op.slot]   <= res;
      upleft_bytes[s2_op.slot] <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (s2_adv) begin
      pix_out.valid <= 1'b1;
    end else if (pix_out.ready) begin
      pix_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      pix_out.pixel_byte  <= s2_op.bad ? '0 : res;
      pix_out.last_of_row <= s2_op.last && !s2_op.bad;
      pix_out.bad_filter  <= s2_op.bad;
    end
  end

endmodule

// ----- src/png_scanline_unfilter.sv -----
// PNG scanline unfilter. Takes the inflated image stream one byte per item: a
// filter-type byte opens each row, then row_bytes filtered bytes follow, each
// rebuilt with the None, Sub, Up, Average or Paeth rule and emitted as one
// result item. A type byte above 4 gives one result with bad_filter set, and
// the stream is then dropped until an item with first_of_image set. The block
// takes one item per clock cycle unless stalled; an item is held in the
// reconstruction stage, then its result in the output register. The previous
// row is in a single-port-read line store, read when the byte is taken and
// used by that stage; it needs no clearing after reset. Input stalls only
// while a result is held in the output register and one more waits behind it.
module png_scanline_unfilter import png_unf_pkg::*; (
  input logic          clk,
  input logic          rst,
  png_unf_in_if.sink   pix_in,
  png_unf_out_if.source pix_out,
  png_unf_cfg_if.sink  cfg
);

  logic              op_push;
  logic              op_ready;
  recon_op_t         op;
  logic              rd_en;
  logic [COL_W-1:0]  rd_addr;
  logic [BYTE_W-1:0] rd_data;
  logic              wr_en;
  logic [COL_W-1:0]  wr_addr;
  logic [BYTE_W-1:0] wr_data;

  png_unf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .pix_in   (pix_in),
    .cfg      (cfg),
    .op_ready (op_ready),
    .op_push  (op_push),
    .op       (op),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr)
  );

  png_unf_line_ram u_line_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  png_unf_recon u_recon (
    .clk      (clk),
    .rst      (rst),
    .op_push  (op_push),
    .op       (op),
    .op_ready (op_ready),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .pix_out  (pix_out)
  );

  a_no_same_entry: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("line store read and write hit the same entry");

  a_stall_needs_full_out: assert property (@(posedge clk) disable iff (rst)
    !pix_in.ready |-> (pix_out.valid && !pix_out.ready))
    else $error("input stalled with a free output register");

  a_bad_result_clean: assert property (@(posedge clk) disable iff (rst)
    (pix_out.valid && pix_out.bad_filter) |->
      (pix_out.pixel_byte == '0 && !pix_out.last_of_row))
    else $error("bad filter result carries data");

  a_push_only_when_free: assert property (@(posedge clk) disable iff (rst)
    op_push |-> op_ready)
    else $error("item pushed into a full stage");

endmodule
